FILE: src/mwprl_pkg.sv
// shared types and constants for the multi-window publish rate limiter
// used by mwprl_window and multi_window_publish_rate_limiter

package mwprl_pkg;

  localparam int WIN_COUNT  = 4;
  localparam int WIN_IDX_W  = 2;
  localparam int COUNT_W    = 32;
  localparam int TIME_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // window lengths in ms
  localparam logic [TIME_W-1:0] LEN_SECOND = 64'd1000;
  localparam logic [TIME_W-1:0] LEN_MINUTE = 64'd60 * 64'd1000;
  localparam logic [TIME_W-1:0] LEN_HOUR   = 64'd60 * 64'd60 * 64'd1000;
  localparam logic [TIME_W-1:0] LEN_DAY    = 64'd24 * 64'd60 * 64'd60 * 64'd1000;

  // blocking window codes, also the register indexes of the maxima
  typedef enum logic [2:0] {
    WIN_SECOND = 3'd0,
    WIN_MINUTE = 3'd1,
    WIN_HOUR   = 3'd2,
    WIN_DAY    = 3'd3,
    WIN_NONE   = 3'd4
  } win_code_t;

  typedef struct packed {
    logic at_limit;
    logic reject;
  } win_stat_t;

  function automatic logic [TIME_W-1:0] win_len(input logic [WIN_IDX_W-1:0] idx);
    logic [TIME_W-1:0] len;
    case (idx)
      2'd0:    len = LEN_SECOND;
      2'd1:    len = LEN_MINUTE;
      2'd2:    len = LEN_HOUR;
      default: len = LEN_DAY;
    endcase
    return len;
  endfunction

endpackage

FILE: src/mwprl_window.sv
// limit check for one fixed window: at-limit and reject status
// depends on mwprl_pkg

module mwprl_window import mwprl_pkg::*; (
  input  logic [WIN_IDX_W-1:0] win_idx,
  input  logic [COUNT_W-1:0]   count,
  input  logic [COUNT_W-1:0]   max_count,
  input  logic [TIME_W-1:0]    start,
  input  logic [TIME_W-1:0]    now_ms,
  output win_stat_t            stat
);

  logic [TIME_W-1:0] elapsed;

  // wraps modulo 2^64
  assign elapsed       = now_ms - start;
  assign stat.at_limit = (count >= max_count);
  assign stat.reject   = stat.at_limit && (elapsed < win_len(win_idx));

endmodule

FILE: src/multi_window_publish_rate_limiter.sv
// multi-window publish rate limiter: second, minute, hour and day windows
// path: an accepted word passes the input register, then the result register
// throughput: one publish word per cycle unless m_tready stalls the output;
//   the four window checks run side by side and the window state updates
//   in the same cycle the result is registered
// reset (rst, synchronous): counters, window starts and maxima cleared, both stages empty
// depends on mwprl_pkg and mwprl_window

module multi_window_publish_rate_limiter import mwprl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // publish requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // [63:0] now_ms
  input  logic [1:0]            s_tuser,   // [0] no_session, [1] no_authorization
  // decisions
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [0] allowed, [7:1] zero
  output logic [2:0]            m_tuser    // [2:0] blocking_window
);

  // configured maxima
  logic [COUNT_W-1:0] max_count [WIN_COUNT];

  // window state
  logic [COUNT_W-1:0] count      [WIN_COUNT];
  logic [COUNT_W-1:0] count_next [WIN_COUNT];
  logic [TIME_W-1:0]  start      [WIN_COUNT];
  logic [TIME_W-1:0]  start_next [WIN_COUNT];

  // input register
  logic              in_valid;
  logic [TIME_W-1:0] in_now;
  logic              in_no_session;
  logic              in_no_auth;

  // result register
  logic      out_valid;
  logic      out_allowed;
  win_code_t out_window;

  logic      advance;
  logic      limits_apply;
  logic      any_reject;
  logic      allowed_next;
  win_code_t window_next;
  win_stat_t stat    [WIN_COUNT];
  logic      reached [WIN_COUNT];
  logic      restart [WIN_COUNT];

  // the held word moves into the result register when that register is free or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_now        <= s_tdata;
      in_no_session <= s_tuser[0];
      in_no_auth    <= s_tuser[1];
    end
  end

  // configuration, index beyond the day window is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_COUNT; i++) begin
        max_count[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(WIN_COUNT))) begin
      max_count[cfg_index[WIN_IDX_W-1:0]] <= cfg_data;
    end
  end

  // one check unit per window
  for (genvar g = 0; g < WIN_COUNT; g++) begin : g_win
    mwprl_window u_win (
      .win_idx   (WIN_IDX_W'(g)),
      .count     (count[g]),
      .max_count (max_count[g]),
      .start     (start[g]),
      .now_ms    (in_now),
      .stat      (stat[g])
    );
  end

  assign limits_apply = !in_no_session && !in_no_auth;

  // priority over the windows: the first rejecting one blocks, later ones are untouched,
  // earlier ones at their limit restart at now
  always_comb begin
    logic blocked;
    blocked     = 1'b0;
    window_next = WIN_NONE;
    for (int i = 0; i < WIN_COUNT; i++) begin
      reached[i] = !blocked;
      restart[i] = !blocked && stat[i].at_limit && !stat[i].reject;
      if (!blocked && stat[i].reject) begin
        window_next = win_code_t'(3'(i));
      end
      blocked = blocked || stat[i].reject;
    end
    any_reject = blocked;
  end

  always_comb begin
    for (int i = 0; i < WIN_COUNT; i++) begin
      count_next[i] = restart[i] ? '0 : count[i];
      start_next[i] = restart[i] ? in_now : start[i];
      if (!any_reject) begin
        count_next[i] = count_next[i] + COUNT_W'(1);
      end
    end
  end

  // decision for the held word
  always_comb begin
    if (in_no_session) begin
      allowed_next = 1'b0;
    end else if (in_no_auth) begin
      allowed_next = 1'b1;
    end else begin
      allowed_next = !any_reject;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_COUNT; i++) begin
        count[i] <= '0;
        start[i] <= '0;
      end
    end else if (advance && limits_apply) begin
      for (int i = 0; i < WIN_COUNT; i++) begin
        if (reached[i]) begin
          count[i] <= count_next[i];
          start[i] <= start_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_allowed <= allowed_next;
      out_window  <= limits_apply ? window_next : WIN_NONE;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_allowed};
  assign m_tuser  = out_window;

endmodule
